// ----- design/ftfs_pkg.sv -----
// ============================================================================
// Frame timer package
// Shared widths, register indexes, reset values and the command and status
// structs between the controller and the datapath.
// ============================================================================
`default_nettype none

package ftfs_pkg;

    localparam int TS_W      = 48;
    localparam int CFG_W     = 20;
    localparam int IVL_W     = 20;
    localparam int SCALE_W   = 16;
    localparam int CNT_W     = 32;
    localparam int SCALED_W  = 28;
    localparam int TICKS_W   = 21;
    localparam int ACC_W     = 21;
    localparam int ACC_SUM_W = 22;
    localparam int FPS_W     = 24;
    localparam int MUL_SHIFT = 8;
    localparam int DVD_W     = CNT_W + IVL_W + MUL_SHIFT;
    localparam int DSR_W     = TS_W;
    localparam int DCNT_W    = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_STEP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_SCALE   = 2'd2;

    localparam logic [CFG_W-1:0]   MAX_INTERVAL_RST = 20'd60000;
    localparam logic [CFG_W-1:0]   FIXED_STEP_RST   = 20'd60000;
    localparam logic [SCALE_W-1:0] TIME_SCALE_RST   = 16'd256;

    localparam logic [IVL_W-1:0] US_PER_S = 20'd1000000;
    localparam logic [FPS_W-1:0] FPS_SAT  = 24'hFFFFFF;

    typedef logic [1:0] div_op_t;
    localparam div_op_t OP_TICK = 2'd0;
    localparam div_op_t OP_WIN  = 2'd1;
    localparam div_op_t OP_AVG  = 2'd2;

    typedef struct packed {
        logic    capture;
        logic    update;
        logic    scale;
        logic    ring;
        logic    div_start;
        div_op_t div_op;
        logic    res_load;
        logic    res_zero;
        logic    out_load;
    } ftfs_cmd_t;

    typedef struct packed {
        logic div_done;
        logic sum_zero;
        logic elapsed_zero;
    } ftfs_sts_t;

endpackage

`default_nettype wire

// ----- design/ftfs_ram.sv -----
// ============================================================================
// Generic RAM
// Single write port and single read port with a registered read.
// ============================================================================
`default_nettype none

module ftfs_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 30
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- design/ftfs_div.sv -----
// ============================================================================
// Radix-2 divider
// Restoring division, one quotient bit per cycle over a left-aligned
// dividend of a given bit count. Done pulses for one cycle at the end.
// ============================================================================
`default_nettype none

module ftfs_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [ftfs_pkg::DVD_W-1:0]  dividend,
    input  wire logic [ftfs_pkg::DSR_W-1:0]  divisor,
    input  wire logic [ftfs_pkg::DCNT_W-1:0] nbits,
    output logic                             done,
    output logic      [ftfs_pkg::DVD_W-1:0]  quotient,
    output logic      [ftfs_pkg::DSR_W-1:0]  remainder
);

    localparam int DVD_W  = ftfs_pkg::DVD_W;
    localparam int DSR_W  = ftfs_pkg::DSR_W;
    localparam int DCNT_W = ftfs_pkg::DCNT_W;

    logic [DSR_W-1:0]  rem_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DSR_W-1:0]  dsr_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DSR_W:0]    trial;
    logic [DSR_W:0]    trial_sub;
    logic              fits;

    assign trial     = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial_sub = trial - {1'b0, dsr_reg};
    assign fits      = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= nbits;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DCNT_W'(1);
                if (cnt_reg == DCNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? trial_sub[DSR_W-1:0] : trial[DSR_W-1:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ----- design/ftfs_dp.sv -----
// ============================================================================
// Frame timer datapath
// Configuration registers, frame state, interval ring with running sum,
// shared divider and the result register.
// ============================================================================
`default_nettype none

module ftfs_dp #(
    parameter int WINDOW = 30
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire ftfs_pkg::ftfs_cmd_t            cmd,
    output ftfs_pkg::ftfs_sts_t                 sts,
    input  wire logic [ftfs_pkg::TS_W-1:0]      s_timestamp_us,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ftfs_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [ftfs_pkg::CFG_W-1:0]     cfg_wdata,
    output logic      [ftfs_pkg::CNT_W-1:0]     m_frame_count,
    output logic      [ftfs_pkg::SCALED_W-1:0]  m_scaled_interval_us,
    output logic      [ftfs_pkg::CNT_W-1:0]     m_fixed_tick_total,
    output logic      [ftfs_pkg::TICKS_W-1:0]   m_new_fixed_ticks,
    output logic      [ftfs_pkg::FPS_W-1:0]     m_window_fps_q8,
    output logic      [ftfs_pkg::FPS_W-1:0]     m_average_fps_q8
);

    localparam int TS_W      = ftfs_pkg::TS_W;
    localparam int IVL_W     = ftfs_pkg::IVL_W;
    localparam int SCALE_W   = ftfs_pkg::SCALE_W;
    localparam int CNT_W     = ftfs_pkg::CNT_W;
    localparam int SCALED_W  = ftfs_pkg::SCALED_W;
    localparam int TICKS_W   = ftfs_pkg::TICKS_W;
    localparam int ACC_W     = ftfs_pkg::ACC_W;
    localparam int ACC_SUM_W = ftfs_pkg::ACC_SUM_W;
    localparam int FPS_W     = ftfs_pkg::FPS_W;
    localparam int DVD_W     = ftfs_pkg::DVD_W;
    localparam int DSR_W     = ftfs_pkg::DSR_W;
    localparam int DCNT_W    = ftfs_pkg::DCNT_W;
    localparam int MUL_SHIFT = ftfs_pkg::MUL_SHIFT;
    localparam int PROD_W    = IVL_W + SCALE_W;
    localparam int FUS_W     = CNT_W + IVL_W;
    localparam int RING_AW   = $clog2(WINDOW);
    localparam int RSUM_W    = SCALED_W + $clog2(WINDOW);

    localparam logic [DVD_W-1:0] WIN_NUM =
        (DVD_W'(WINDOW) * DVD_W'(ftfs_pkg::US_PER_S)) << MUL_SHIFT;
    localparam int WIN_BITS = $clog2(WIN_NUM + DVD_W'(1));
    localparam logic [DVD_W-1:0] WIN_NUM_AL = WIN_NUM << (DVD_W - WIN_BITS);

    function automatic logic [FPS_W-1:0] fps_sat(input logic [DVD_W-1:0] q);
        if (|q[DVD_W-1:FPS_W]) begin
            fps_sat = ftfs_pkg::FPS_SAT;
        end else begin
            fps_sat = q[FPS_W-1:0];
        end
    endfunction

    // Configuration.
    logic [IVL_W-1:0]   max_ivl_reg;
    logic [IVL_W-1:0]   fixed_step_reg;
    logic [SCALE_W-1:0] time_scale_reg;

    // Frame state.
    logic                started_reg;
    logic [TS_W-1:0]     last_ts_reg;
    logic [TS_W-1:0]     elapsed_reg;
    logic [CNT_W-1:0]    frames_reg;
    logic [ACC_W-1:0]    step_acc_reg;
    logic [CNT_W-1:0]    ticks_total_reg;
    logic [RING_AW-1:0]  pos_reg;
    logic [RSUM_W-1:0]   sum_reg;
    logic [WINDOW-1:0]   ring_vld_reg;

    // Working registers.
    logic [TS_W-1:0]      ts_reg;
    logic [IVL_W-1:0]     clamped_reg;
    logic [SCALED_W-1:0]  scaled_reg;
    logic [ACC_SUM_W-1:0] acc_sum_reg;
    logic [DVD_W-1:0]     avg_num_reg;
    logic [SCALED_W-1:0]  old_ring_reg;
    logic [TICKS_W-1:0]   ticks_reg;
    logic [FPS_W-1:0]     win_fps_reg;
    logic [FPS_W-1:0]     avg_fps_reg;

    // Result register.
    logic [CNT_W-1:0]    out_frames_reg;
    logic [SCALED_W-1:0] out_scaled_reg;
    logic [CNT_W-1:0]    out_total_reg;
    logic [TICKS_W-1:0]  out_ticks_reg;
    logic [FPS_W-1:0]    out_win_reg;
    logic [FPS_W-1:0]    out_avg_reg;

    logic [TS_W-1:0]     ts_base;
    logic [TS_W-1:0]     diff;
    logic [IVL_W-1:0]    clamped_next;
    logic [PROD_W-1:0]   prod;
    logic [FUS_W-1:0]    frames_us;
    logic [IVL_W-1:0]    step_eff;
    logic [RING_AW-1:0]  pos_next;
    logic [SCALED_W-1:0] ram_q;
    logic [DVD_W-1:0]    div_dividend;
    logic [DSR_W-1:0]    div_divisor;
    logic [DCNT_W-1:0]   div_nbits;
    logic                div_done;
    logic [DVD_W-1:0]    div_quo;
    logic [DSR_W-1:0]    div_rem;

    always_comb begin
        ts_base = started_reg ? last_ts_reg : ts_reg;
        diff    = ts_reg - ts_base;
        if (diff[TS_W-1]) begin
            clamped_next = '0;
        end else if (diff > TS_W'(max_ivl_reg)) begin
            clamped_next = max_ivl_reg;
        end else begin
            clamped_next = diff[IVL_W-1:0];
        end
    end

    assign prod      = PROD_W'(clamped_reg) * PROD_W'(time_scale_reg);
    assign frames_us = FUS_W'(frames_reg) * FUS_W'(ftfs_pkg::US_PER_S);
    assign step_eff  = (fixed_step_reg == '0) ? IVL_W'(1) : fixed_step_reg;
    assign pos_next  = (pos_reg == RING_AW'(WINDOW - 1)) ? '0 : pos_reg + RING_AW'(1);

    always_comb begin
        case (cmd.div_op)
            ftfs_pkg::OP_TICK: begin
                div_dividend = {acc_sum_reg, (DVD_W - ACC_SUM_W)'(0)};
                div_divisor  = DSR_W'(step_eff);
                div_nbits    = DCNT_W'(ACC_SUM_W);
            end
            ftfs_pkg::OP_WIN: begin
                div_dividend = WIN_NUM_AL;
                div_divisor  = DSR_W'(sum_reg);
                div_nbits    = DCNT_W'(WIN_BITS);
            end
            ftfs_pkg::OP_AVG: begin
                div_dividend = avg_num_reg;
                div_divisor  = elapsed_reg;
                div_nbits    = DCNT_W'(DVD_W);
            end
            default: begin
                div_dividend = '0;
                div_divisor  = '0;
                div_nbits    = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_ivl_reg    <= ftfs_pkg::MAX_INTERVAL_RST;
            fixed_step_reg <= ftfs_pkg::FIXED_STEP_RST;
            time_scale_reg <= ftfs_pkg::TIME_SCALE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                ftfs_pkg::REG_MAX_INTERVAL: max_ivl_reg    <= cfg_wdata;
                ftfs_pkg::REG_FIXED_STEP:   fixed_step_reg <= cfg_wdata;
                ftfs_pkg::REG_TIME_SCALE:   time_scale_reg <= cfg_wdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg     <= 1'b0;
            last_ts_reg     <= '0;
            elapsed_reg     <= '0;
            frames_reg      <= '0;
            step_acc_reg    <= '0;
            ticks_total_reg <= '0;
            pos_reg         <= '0;
            sum_reg         <= '0;
            ring_vld_reg    <= '0;
        end else begin
            if (cmd.update) begin
                started_reg <= 1'b1;
                last_ts_reg <= ts_reg;
                elapsed_reg <= elapsed_reg + diff;
                frames_reg  <= frames_reg + CNT_W'(1);
            end
            if (cmd.ring) begin
                ring_vld_reg[pos_reg] <= 1'b1;
                sum_reg <= sum_reg - RSUM_W'(old_ring_reg) + RSUM_W'(scaled_reg);
                pos_reg <= pos_next;
            end
            if (cmd.res_load && cmd.div_op == ftfs_pkg::OP_TICK) begin
                step_acc_reg    <= div_rem[ACC_W-1:0];
                ticks_total_reg <= ticks_total_reg + div_quo[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            ts_reg <= s_timestamp_us;
        end
        if (cmd.update) begin
            clamped_reg <= clamped_next;
        end
        if (cmd.scale) begin
            scaled_reg   <= prod[PROD_W-1:MUL_SHIFT];
            acc_sum_reg  <= ACC_SUM_W'(step_acc_reg) + ACC_SUM_W'(clamped_reg);
            avg_num_reg  <= {frames_us, MUL_SHIFT'(0)};
            old_ring_reg <= ring_vld_reg[pos_reg] ? ram_q : '0;
        end
        if (cmd.res_load) begin
            case (cmd.div_op)
                ftfs_pkg::OP_TICK: ticks_reg   <= div_quo[TICKS_W-1:0];
                ftfs_pkg::OP_WIN:  win_fps_reg <= cmd.res_zero ? '0 : fps_sat(div_quo);
                ftfs_pkg::OP_AVG:  avg_fps_reg <= cmd.res_zero ? '0 : fps_sat(div_quo);
                default: ;
            endcase
        end
        if (cmd.out_load) begin
            out_frames_reg <= frames_reg;
            out_scaled_reg <= scaled_reg;
            out_total_reg  <= ticks_total_reg;
            out_ticks_reg  <= ticks_reg;
            out_win_reg    <= win_fps_reg;
            out_avg_reg    <= avg_fps_reg;
        end
    end

    ftfs_ram #(
        .WIDTH(SCALED_W),
        .DEPTH(WINDOW)
    ) u_ring (
        .aclk   (aclk),
        .wr_en  (cmd.ring),
        .wr_addr(pos_reg),
        .wr_data(scaled_reg),
        .rd_addr(pos_reg),
        .rd_data(ram_q)
    );

    ftfs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .nbits    (div_nbits),
        .done     (div_done),
        .quotient (div_quo),
        .remainder(div_rem)
    );

    assign sts.div_done     = div_done;
    assign sts.sum_zero     = (sum_reg == '0);
    assign sts.elapsed_zero = (elapsed_reg == '0);

    assign m_frame_count        = out_frames_reg;
    assign m_scaled_interval_us = out_scaled_reg;
    assign m_fixed_tick_total   = out_total_reg;
    assign m_new_fixed_ticks    = out_ticks_reg;
    assign m_window_fps_q8      = out_win_reg;
    assign m_average_fps_q8     = out_avg_reg;

endmodule

`default_nettype wire

// ----- design/ftfs_ctrl.sv -----
// ============================================================================
// Frame timer controller
// Sequences one transaction through update, scaling, ring write and the
// three divisions, then hands the result to the output register.
// ============================================================================
`default_nettype none

module ftfs_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ftfs_pkg::ftfs_cmd_t      cmd,
    input  wire ftfs_pkg::ftfs_sts_t sts
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_UPD    = 4'd1;
    localparam logic [3:0] S_MUL    = 4'd2;
    localparam logic [3:0] S_RING   = 4'd3;
    localparam logic [3:0] S_TDIV   = 4'd4;
    localparam logic [3:0] S_WSTART = 4'd5;
    localparam logic [3:0] S_WDIV   = 4'd6;
    localparam logic [3:0] S_ASTART = 4'd7;
    localparam logic [3:0] S_ADIV   = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       m_valid_reg;

    always_comb begin
        cmd        = '0;
        cmd.div_op = ftfs_pkg::OP_TICK;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = S_UPD;
                end
            end
            S_UPD: begin
                cmd.update = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.scale  = 1'b1;
                state_next = S_RING;
            end
            S_RING: begin
                cmd.ring      = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_TDIV;
            end
            S_TDIV: begin
                if (sts.div_done) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_WSTART;
                end
            end
            S_WSTART: begin
                cmd.div_op = ftfs_pkg::OP_WIN;
                if (sts.sum_zero) begin
                    cmd.res_load = 1'b1;
                    cmd.res_zero = 1'b1;
                    state_next   = S_ASTART;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_WDIV;
                end
            end
            S_WDIV: begin
                cmd.div_op = ftfs_pkg::OP_WIN;
                if (sts.div_done) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_ASTART;
                end
            end
            S_ASTART: begin
                cmd.div_op = ftfs_pkg::OP_AVG;
                if (sts.elapsed_zero) begin
                    cmd.res_load = 1'b1;
                    cmd.res_zero = 1'b1;
                    state_next   = S_OUT;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_ADIV;
                end
            end
            S_ADIV: begin
                cmd.div_op = ftfs_pkg::OP_AVG;
                if (sts.div_done) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ----- design/frame_timer_fixed_step.sv -----
// Each transaction steps through update, scaling and ring write, then the shared
// radix-2 divider runs the tick, window and average divisions over 22, 33 and 60
// dividend bits. A zero FPS divisor skips its division. The next timestamp is taken
// once the previous result is loaded, while that result may still wait for m_ready.
// Reset (aresetn low, synchronous) restores register defaults and the frame state.
// ============================================================================
// Frame timer with fixed-step accumulator
// Top level: joins the controller and the datapath.
// ============================================================================
`default_nettype none

module frame_timer_fixed_step #(
    parameter int WINDOW = 30
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [ftfs_pkg::TS_W-1:0]      s_timestamp_us,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [ftfs_pkg::CNT_W-1:0]     m_frame_count,
    output logic      [ftfs_pkg::SCALED_W-1:0]  m_scaled_interval_us,
    output logic      [ftfs_pkg::CNT_W-1:0]     m_fixed_tick_total,
    output logic      [ftfs_pkg::TICKS_W-1:0]   m_new_fixed_ticks,
    output logic      [ftfs_pkg::FPS_W-1:0]     m_window_fps_q8,
    output logic      [ftfs_pkg::FPS_W-1:0]     m_average_fps_q8,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ftfs_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [ftfs_pkg::CFG_W-1:0]     cfg_wdata
);

    ftfs_pkg::ftfs_cmd_t cmd;
    ftfs_pkg::ftfs_sts_t sts;

    ftfs_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .cmd    (cmd),
        .sts    (sts)
    );

    ftfs_dp #(
        .WINDOW(WINDOW)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .sts                 (sts),
        .s_timestamp_us      (s_timestamp_us),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_addr            (cfg_addr),
        .cfg_wdata           (cfg_wdata),
        .m_frame_count       (m_frame_count),
        .m_scaled_interval_us(m_scaled_interval_us),
        .m_fixed_tick_total  (m_fixed_tick_total),
        .m_new_fixed_ticks   (m_new_fixed_ticks),
        .m_window_fps_q8     (m_window_fps_q8),
        .m_average_fps_q8    (m_average_fps_q8)
    );

endmodule

`default_nettype wire

// ----- design/ftfs_chk.sv -----
// ============================================================================
// Frame timer port checker
// Watches the top-level ports for transaction ordering and result hold.
// ============================================================================
`default_nettype none

module ftfs_chk (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [ftfs_pkg::CNT_W-1:0]    m_frame_count,
    input wire logic [ftfs_pkg::SCALED_W-1:0] m_scaled_interval_us,
    input wire logic [ftfs_pkg::CNT_W-1:0]    m_fixed_tick_total,
    input wire logic [ftfs_pkg::TICKS_W-1:0]  m_new_fixed_ticks,
    input wire logic [ftfs_pkg::FPS_W-1:0]    m_window_fps_q8,
    input wire logic [ftfs_pkg::FPS_W-1:0]    m_average_fps_q8
);

    logic                       in_acc;
    logic                       out_acc;
    logic [1:0]                 pend_reg;
    logic [ftfs_pkg::CNT_W-1:0] last_fc_reg;
    logic                       seen_reg;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= '0;
            last_fc_reg <= '0;
            seen_reg    <= 1'b0;
        end else begin
            pend_reg <= pend_reg + {1'b0, in_acc} - {1'b0, out_acc};
            if (out_acc) begin
                last_fc_reg <= m_frame_count;
                seen_reg    <= 1'b1;
            end
        end
    end

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_ready)
        else $error("input taken in two consecutive cycles");

    a_result_has_source: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != 2'd0)
        else $error("result shown with no outstanding transaction");

    a_frame_count_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && seen_reg |-> m_frame_count == last_fc_reg + ftfs_pkg::CNT_W'(1))
        else $error("frame count did not advance by one between results");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_count)
            && $stable(m_scaled_interval_us) && $stable(m_fixed_tick_total)
            && $stable(m_new_fixed_ticks) && $stable(m_window_fps_q8)
            && $stable(m_average_fps_q8))
        else $error("stalled result changed");

endmodule

bind frame_timer_fixed_step ftfs_chk u_ftfs_chk (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .s_valid             (s_valid),
    .s_ready             (s_ready),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_frame_count       (m_frame_count),
    .m_scaled_interval_us(m_scaled_interval_us),
    .m_fixed_tick_total  (m_fixed_tick_total),
    .m_new_fixed_ticks   (m_new_fixed_ticks),
    .m_window_fps_q8     (m_window_fps_q8),
    .m_average_fps_q8    (m_average_fps_q8)
);

`default_nettype wire

// ----- tb/tb_frame_timer_fixed_step.sv -----
// ============================================================================
// Frame timer with fixed-step accumulator: testbench
// This testbench sends frame timestamps over a valid/ready channel. It
// predicts each result from its own model of the timer, which covers clamping,
// scaling, tick accumulation, the interval window and both FPS divisions. It
// checks every result field by field. The run covers several register
// settings and several patterns of sender idling and receiver stalls.
// ============================================================================
`timescale 1ns / 1ps

module tb_frame_timer_fixed_step;

    localparam int TS_W      = ftfs_pkg::TS_W;
    localparam int CFG_W     = ftfs_pkg::CFG_W;
    localparam int IVL_W     = ftfs_pkg::IVL_W;
    localparam int SCALE_W   = ftfs_pkg::SCALE_W;
    localparam int CNT_W     = ftfs_pkg::CNT_W;
    localparam int SCALED_W  = ftfs_pkg::SCALED_W;
    localparam int TICKS_W   = ftfs_pkg::TICKS_W;
    localparam int ACC_W     = ftfs_pkg::ACC_W;
    localparam int ACC_SUM_W = ftfs_pkg::ACC_SUM_W;
    localparam int FPS_W     = ftfs_pkg::FPS_W;
    localparam int MUL_SHIFT = ftfs_pkg::MUL_SHIFT;
    localparam int CFG_IDX_W = ftfs_pkg::CFG_IDX_W;

    localparam int WINDOW = 30;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int PHASES = 8;
    localparam int RX_HOLD_CYCLES = 3000;

    typedef struct packed {
        logic [CNT_W-1:0]    frame_count;
        logic [SCALED_W-1:0] scaled_interval;
        logic [CNT_W-1:0]    tick_total;
        logic [TICKS_W-1:0]  new_ticks;
        logic [FPS_W-1:0]    window_fps;
        logic [FPS_W-1:0]    average_fps;
    } frame_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [TS_W-1:0]      s_timestamp_us = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [CNT_W-1:0]     m_frame_count;
    logic [SCALED_W-1:0]  m_scaled_interval_us;
    logic [CNT_W-1:0]     m_fixed_tick_total;
    logic [TICKS_W-1:0]   m_new_fixed_ticks;
    logic [FPS_W-1:0]     m_window_fps_q8;
    logic [FPS_W-1:0]     m_average_fps_q8;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    logic [TS_W-1:0]  ts_pending[$];
    frame_result_t    frame_expect[$];

    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    logic        rx_hold_start = 1'b0;
    int unsigned rx_hold_left = 0;
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;

    logic [CFG_W-1:0]   cfg_max_us = ftfs_pkg::MAX_INTERVAL_RST;
    logic [CFG_W-1:0]   cfg_step_us = ftfs_pkg::FIXED_STEP_RST;
    logic [SCALE_W-1:0] cfg_scale = ftfs_pkg::TIME_SCALE_RST;

    logic                seen_first = 1'b0;
    logic [TS_W-1:0]     prev_stamp = '0;
    logic [TS_W-1:0]     elapsed_sum = '0;
    logic [CNT_W-1:0]    pred_frames = '0;
    logic [ACC_W-1:0]    step_residue = '0;
    logic [CNT_W-1:0]    tick_total = '0;
    logic [SCALED_W-1:0] interval_hist[WINDOW];
    int unsigned         hist_pos = 0;
    logic [63:0]         hist_sum = '0;
    logic [TS_W-1:0]     gen_stamp = '0;

    frame_timer_fixed_step #(
        .WINDOW(WINDOW)
    ) dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_timestamp_us       (s_timestamp_us),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_frame_count        (m_frame_count),
        .m_scaled_interval_us (m_scaled_interval_us),
        .m_fixed_tick_total   (m_fixed_tick_total),
        .m_new_fixed_ticks    (m_new_fixed_ticks),
        .m_window_fps_q8      (m_window_fps_q8),
        .m_average_fps_q8     (m_average_fps_q8),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_addr             (cfg_addr),
        .cfg_wdata            (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [FPS_W-1:0] fps_q8(input logic [63:0] count,
                                                input logic [63:0] span);
        logic [63:0] q;
        if (span == 0) begin
            return '0;
        end
        q = (count * (64'(ftfs_pkg::US_PER_S) * 64'd256)) / span;
        return (q > 64'(ftfs_pkg::FPS_SAT)) ? ftfs_pkg::FPS_SAT : q[FPS_W-1:0];
    endfunction

    function automatic void predict_frame(input logic [TS_W-1:0] stamp);
        logic [TS_W-1:0]       gap;
        logic [IVL_W-1:0]      clamped;
        logic [35:0]           product;
        logic [SCALED_W-1:0]   scaled;
        logic [ACC_SUM_W-1:0]  acc;
        logic [ACC_SUM_W-1:0]  step;
        logic [ACC_SUM_W-1:0]  ticks;
        frame_result_t         r;
        if (!seen_first) begin
            prev_stamp = stamp;
            seen_first = 1'b1;
        end
        pred_frames = pred_frames + CNT_W'(1);
        gap = stamp - prev_stamp;
        prev_stamp = stamp;
        elapsed_sum = elapsed_sum + gap;

        if (gap[TS_W-1]) begin
            clamped = '0;
        end else if (gap > TS_W'(cfg_max_us)) begin
            clamped = cfg_max_us;
        end else begin
            clamped = gap[IVL_W-1:0];
        end
        product = 36'(clamped) * 36'(cfg_scale);
        scaled = product[MUL_SHIFT +: SCALED_W];

        step = (cfg_step_us == 0) ? ACC_SUM_W'(1) : ACC_SUM_W'(cfg_step_us);
        acc = ACC_SUM_W'(step_residue) + ACC_SUM_W'(clamped);
        ticks = acc / step;
        step_residue = ACC_W'(acc % step);
        tick_total = tick_total + CNT_W'(ticks);

        hist_sum = hist_sum - 64'(interval_hist[hist_pos]) + 64'(scaled);
        interval_hist[hist_pos] = scaled;
        hist_pos = (hist_pos == WINDOW - 1) ? 0 : hist_pos + 1;

        r.frame_count = pred_frames;
        r.scaled_interval = scaled;
        r.tick_total = tick_total;
        r.new_ticks = ticks[TICKS_W-1:0];
        r.window_fps = fps_q8(64'(WINDOW), hist_sum);
        r.average_fps = fps_q8(64'(pred_frames), 64'(elapsed_sum));
        frame_expect.push_back(r);
    endfunction

    // Mostly plausible frame-to-frame steps around the clamp, with some
    // backward, wrapping, sign-boundary and fully random timestamps mixed in.
    function automatic logic [TS_W-1:0] next_stamp();
        int unsigned     pick;
        logic [TS_W-1:0] delta;
        pick = $urandom_range(99);
        delta = '0;
        if (pick < 40) begin
            delta = TS_W'($urandom_range(70000, 8000));
        end else if (pick < 55) begin
            delta = TS_W'($urandom_range(32'(cfg_max_us) + 32'(cfg_max_us) / 4 + 2));
        end else if (pick < 65) begin
            delta = TS_W'($urandom_range(32'(cfg_max_us) + 2,
                                         (cfg_max_us >= 2) ? 32'(cfg_max_us) - 2 : 0));
        end else if (pick < 75) begin
            delta = TS_W'($urandom_range(16));
        end else if (pick < 82) begin
            delta = TS_W'({$urandom, $urandom});
        end else if (pick < 90) begin
            delta = TS_W'(0) - TS_W'($urandom_range(100000, 1));
        end else if (pick < 95) begin
            gen_stamp = TS_W'({$urandom, $urandom});
        end else if (pick < 97) begin
            delta = $urandom_range(1) ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
        end
        gen_stamp = gen_stamp + delta;
        return gen_stamp;
    endfunction

    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (ts_pending.size() != 0 || s_valid || frame_expect.size() != 0);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        case (idx)
            ftfs_pkg::REG_MAX_INTERVAL: cfg_max_us = value;
            ftfs_pkg::REG_FIXED_STEP:   cfg_step_us = value;
            ftfs_pkg::REG_TIME_SCALE:   cfg_scale = value[SCALE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: result %0d, %s: expected %0d, got %0d",
                         $time, results_seen, name, want, got);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_frame(s_timestamp_us);
            end
            if (!s_valid || s_ready) begin
                if (ts_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_valid <= 1'b1;
                    s_timestamp_us <= ts_pending.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (rx_hold_start) begin
            rx_hold_left <= RX_HOLD_CYCLES;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        frame_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (frame_expect.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result %0d arrived with no transaction pending",
                                 $time, results_seen);
                    end
                end else begin
                    want = frame_expect.pop_front();
                    check_field("frame_count", want.frame_count, m_frame_count);
                    check_field("scaled_interval_us", want.scaled_interval,
                                m_scaled_interval_us);
                    check_field("fixed_tick_total", want.tick_total, m_fixed_tick_total);
                    check_field("new_fixed_ticks", want.new_ticks, m_new_fixed_ticks);
                    check_field("window_fps_q8", want.window_fps, m_window_fps_q8);
                    check_field("average_fps_q8", want.average_fps, m_average_fps_q8);
                end
            end
            m_ready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial begin
        int unsigned     tx_modes[4];
        int unsigned     rx_modes[4];
        int unsigned     left;
        int unsigned     chunk;
        int              phase;
        logic [TS_W-1:0] t;

        tx_modes = '{0, 85, 0, 17};
        rx_modes = '{0, 0, 85, 17};
        foreach (interval_hist[i]) begin
            interval_hist[i] = '0;
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        for (phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            if (phase != 0) begin
                case (phase)
                    1: begin
                        cfg_write(ftfs_pkg::REG_MAX_INTERVAL, 20'd1);
                        cfg_write(ftfs_pkg::REG_FIXED_STEP, 20'd1);
                        cfg_write(ftfs_pkg::REG_TIME_SCALE, 20'd0);
                    end
                    2: begin
                        cfg_write(ftfs_pkg::REG_TIME_SCALE, 20'hFFFF);
                        cfg_write(ftfs_pkg::REG_MAX_INTERVAL, 20'd0);
                        cfg_write(ftfs_pkg::REG_FIXED_STEP, 20'd0);
                    end
                    3: begin
                        cfg_write(REG_UNUSED, CFG_W'($urandom));
                        cfg_write(ftfs_pkg::REG_MAX_INTERVAL, 20'hFFFFF);
                        cfg_write(ftfs_pkg::REG_FIXED_STEP, 20'hFFFFF);
                        cfg_write(ftfs_pkg::REG_TIME_SCALE, 20'hFFFFF);
                    end
                    4: begin
                        cfg_write(ftfs_pkg::REG_MAX_INTERVAL, 20'd1000000);
                        cfg_write(ftfs_pkg::REG_FIXED_STEP, 20'd16667);
                        cfg_write(ftfs_pkg::REG_TIME_SCALE, 20'd128);
                    end
                    5: begin
                        cfg_write(ftfs_pkg::REG_FIXED_STEP, 20'd1000000);
                        cfg_write(ftfs_pkg::REG_MAX_INTERVAL, 20'd16667);
                        cfg_write(ftfs_pkg::REG_TIME_SCALE, 20'd512);
                    end
                    default: begin
                        cfg_write(ftfs_pkg::REG_MAX_INTERVAL,
                                  CFG_W'($urandom_range(1000000, 1)));
                        cfg_write(ftfs_pkg::REG_FIXED_STEP,
                                  CFG_W'($urandom_range(1000000, 1)));
                        cfg_write(ftfs_pkg::REG_TIME_SCALE, CFG_W'($urandom_range(65535)));
                        cfg_write(REG_UNUSED, CFG_W'($urandom));
                    end
                endcase
                @(posedge aclk);
                cfg_wr_en <= 1'b0;
            end

            @(negedge aclk);
            tx_idle_pct = tx_modes[phase % 4];
            rx_stall_pct = rx_modes[phase % 4];
            left = ITEMS_PER_PHASE;

            if (phase == 0) begin
                // The first frame only latches its time. Later frames wrap
                // past zero, repeat a time, sit on and just past the clamp,
                // go backward, cross the sign boundary of the interval, come
                // back to the first time so the elapsed sum is zero, and end
                // in a run of one-microsecond frames that saturates the average FPS.
                t = 48'hFFFF_FFFF_FFF0;
                ts_pending.push_back(t);
                t = 48'h0000_0000_0010;
                ts_pending.push_back(t);
                ts_pending.push_back(t);
                t = t + 48'd60000;
                ts_pending.push_back(t);
                t = t + 48'd60001;
                ts_pending.push_back(t);
                t = t + 48'd59999;
                ts_pending.push_back(t);
                t = t + 48'd120000;
                ts_pending.push_back(t);
                t = t - 48'd1000;
                ts_pending.push_back(t);
                t = t + 48'h8000_0000_0000;
                ts_pending.push_back(t);
                t = t + 48'h7FFF_FFFF_FFFF;
                ts_pending.push_back(t);
                t = 48'hFFFF_FFFF_FFF0;
                ts_pending.push_back(t);
                t = 48'hFFFF_FFFF_FFFF;
                ts_pending.push_back(t);
                t = '0;
                ts_pending.push_back(t);
                repeat (7) begin
                    t = t + TS_W'(1);
                    ts_pending.push_back(t);
                end
                gen_stamp = t;
                left = left - ts_pending.size();
                wait_drained();
            end

            if (phase == 4) begin
                rx_hold_start = 1'b1;
                @(negedge aclk);
                rx_hold_start = 1'b0;
            end

            while (left > 0) begin
                chunk = $urandom_range(80, 20);
                if (chunk > left) begin
                    chunk = left;
                end
                repeat (chunk) ts_pending.push_back(next_stamp());
                left = left - chunk;
                wait_drained();
            end
        end

        wait_drained();
        repeat (300) @(posedge aclk);
        if (mismatches == 0 && frame_expect.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
